[rtl/ncc_pkg.sv]
// Shared types and constants of the nearest-centroid confusion counter.
// No dependencies; imported by the cell, counter and top-level modules.
`default_nettype none

package ncc_pkg;

    localparam int FIELD_BITS    = 3;
    localparam int MODE_BITS     = 2;
    localparam int DIST_OUT_BITS = 26;
    localparam int CFG_IDX_BITS  = 3;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_CLASSIFY = 2'd0,
        MODE_READ     = 2'd1,
        MODE_CLEAR    = 2'd2,
        MODE_NONE     = 2'd3
    } t_mode;

    // item control fields that travel along the cell chain
    typedef struct packed {
        t_mode                 mode;
        logic [FIELD_BITS-1:0] row;
        logic [FIELD_BITS-1:0] col;
        logic [FIELD_BITS-1:0] win;
    } t_tag;

endpackage

`default_nettype wire

[rtl/nearest_centroid_confusion_counter_unit.sv]
// Path of an item: the centroid cell registers in chain order, the counter read
// register and the result register. Throughput: one item per cycle unless the
// output stalls; a counter hit by consecutive items is forwarded.
// Reset (synchronous, active low): centroids zero, counter valid bits cleared
// at once so every counter reads zero; no clearing pass.
// Top level: chain of ncc_cell instances feeding ncc_count; uses ncc_pkg.
`default_nettype none

module nearest_centroid_confusion_counter_unit #(
    parameter int NUM_CLASSES = 6,
    parameter int SAMPLE_BITS = 12,
    parameter int COUNT_BITS  = 16,
    localparam int IN_W  = ((2*ncc_pkg::FIELD_BITS + 3*SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((ncc_pkg::FIELD_BITS + ncc_pkg::DIST_OUT_BITS
                             + COUNT_BITS + 7) / 8) * 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // true_class, sample_x, sample_y, sample_z, read_column
    input  wire logic [IN_W-1:0]                   s_axis_tdata,
    // mode
    input  wire logic [ncc_pkg::MODE_BITS-1:0]     s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // winner, min_squared_distance, count_value
    output logic [OUT_W-1:0]                       m_axis_tdata,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [ncc_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [3*SAMPLE_BITS-1:0]          i_cfg_wdata
);
    import ncc_pkg::*;

    localparam int N         = NUM_CLASSES;
    localparam int SB        = SAMPLE_BITS;
    localparam int DIST_BITS = 2 * SB + 2;

    logic [N:0]                c_valid;
    logic [N:0]                c_ready;
    t_tag                      c_tag  [N+1];
    logic [N:0][SB-1:0]        c_x, c_y, c_z;
    logic [N:0][DIST_BITS-1:0] c_best;

    logic [FIELD_BITS-1:0]    res_win;
    logic [DIST_OUT_BITS-1:0] res_dist;
    logic [COUNT_BITS-1:0]    res_cnt;

    assign c_valid[0]    = s_axis_tvalid;
    assign s_axis_tready = c_ready[0];
    assign c_tag[0]      = '{mode: t_mode'(s_axis_tuser),
                             row:  s_axis_tdata[0 +: FIELD_BITS],
                             col:  s_axis_tdata[FIELD_BITS + 3*SB +: FIELD_BITS],
                             win:  '0};
    assign c_x[0]    = s_axis_tdata[FIELD_BITS +: SB];
    assign c_y[0]    = s_axis_tdata[FIELD_BITS + SB +: SB];
    assign c_z[0]    = s_axis_tdata[FIELD_BITS + 2*SB +: SB];
    assign c_best[0] = '0;

    for (genvar k = 0; k < N; k++) begin : g_cell
        ncc_cell #(
            .CELL_IDX    (k),
            .SAMPLE_BITS (SB),
            .DIST_BITS   (DIST_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cfg_wr_en (i_cfg_wr_en),
            .i_cfg_index (i_cfg_index),
            .i_cfg_wdata (i_cfg_wdata),
            .i_valid     (c_valid[k]),
            .o_ready     (c_ready[k]),
            .i_tag       (c_tag[k]),
            .i_x         (c_x[k]),
            .i_y         (c_y[k]),
            .i_z         (c_z[k]),
            .i_best      (c_best[k]),
            .o_valid     (c_valid[k+1]),
            .i_ready     (c_ready[k+1]),
            .o_tag       (c_tag[k+1]),
            .o_x         (c_x[k+1]),
            .o_y         (c_y[k+1]),
            .o_z         (c_z[k+1]),
            .o_best      (c_best[k+1])
        );
    end

    ncc_count #(
        .NUM_CLASSES (N),
        .COUNT_BITS  (COUNT_BITS),
        .DIST_BITS   (DIST_BITS)
    ) u_count (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (c_valid[N]),
        .o_ready                (c_ready[N]),
        .i_tag                  (c_tag[N]),
        .i_best                 (c_best[N]),
        .o_valid                (m_axis_tvalid),
        .i_ready                (m_axis_tready),
        .o_winner               (res_win),
        .o_min_squared_distance (res_dist),
        .o_count_value          (res_cnt)
    );

    assign m_axis_tdata = OUT_W'({res_cnt, res_dist, res_win});

`ifndef ASSERT_OFF
    a_full_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (&c_valid[N:1]))
        else $error("input stalled while the cell chain has a bubble");

    a_winner_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ({1'b0, m_axis_tdata[FIELD_BITS-1:0]}
                           < (FIELD_BITS+1)'(NUM_CLASSES)))
        else $error("winner index beyond the centroid count");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

[rtl/ncc_cell.sv]
// One cell of the classifier chain: holds one centroid, computes the squared
// distance of the passing item and keeps the running nearest. Uses ncc_pkg.
`default_nettype none

module ncc_cell #(
    parameter int CELL_IDX    = 0,
    parameter int SAMPLE_BITS = 12,
    parameter int DIST_BITS   = 26
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [ncc_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [3*SAMPLE_BITS-1:0]          i_cfg_wdata,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire ncc_pkg::t_tag                     i_tag,
    input  wire logic [SAMPLE_BITS-1:0]            i_x,
    input  wire logic [SAMPLE_BITS-1:0]            i_y,
    input  wire logic [SAMPLE_BITS-1:0]            i_z,
    input  wire logic [DIST_BITS-1:0]              i_best,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output ncc_pkg::t_tag                          o_tag,
    output logic [SAMPLE_BITS-1:0]                 o_x,
    output logic [SAMPLE_BITS-1:0]                 o_y,
    output logic [SAMPLE_BITS-1:0]                 o_z,
    output logic [DIST_BITS-1:0]                   o_best
);
    import ncc_pkg::*;

    localparam int SQ_BITS = 2 * SAMPLE_BITS;

    logic [3*SAMPLE_BITS-1:0] r_centroid;
    logic                     r_valid;
    t_tag                     r_tag;
    logic [SAMPLE_BITS-1:0]   r_x, r_y, r_z;
    logic [DIST_BITS-1:0]     r_best;

    logic [SAMPLE_BITS-1:0] cx, cy, cz, dx, dy, dz;
    logic [SQ_BITS-1:0]     sx, sy, sz;
    logic [DIST_BITS-1:0]   sq_dist;
    logic                   take;
    t_tag                   n_tag;
    logic [DIST_BITS-1:0]   n_best;

    assign cx = r_centroid[0 +: SAMPLE_BITS];
    assign cy = r_centroid[SAMPLE_BITS +: SAMPLE_BITS];
    assign cz = r_centroid[2*SAMPLE_BITS +: SAMPLE_BITS];

    always_comb begin
        dx      = (i_x >= cx) ? i_x - cx : cx - i_x;
        dy      = (i_y >= cy) ? i_y - cy : cy - i_y;
        dz      = (i_z >= cz) ? i_z - cz : cz - i_z;
        sx      = SQ_BITS'(dx) * SQ_BITS'(dx);
        sy      = SQ_BITS'(dy) * SQ_BITS'(dy);
        sz      = SQ_BITS'(dz) * SQ_BITS'(dz);
        sq_dist = DIST_BITS'(sx) + DIST_BITS'(sy) + DIST_BITS'(sz);
        // ties go to the later centroid
        take   = (CELL_IDX == 0) || (sq_dist <= i_best);
        n_best = take ? sq_dist : i_best;
        n_tag  = i_tag;
        if (take) begin
            n_tag.win = FIELD_BITS'(CELL_IDX);
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centroid <= '0;
            r_valid    <= 1'b0;
        end else begin
            if (i_cfg_wr_en && i_cfg_index == CFG_IDX_BITS'(CELL_IDX)) begin
                r_centroid <= i_cfg_wdata;
            end
            if (o_ready) begin
                r_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_tag  <= n_tag;
            r_x    <= i_x;
            r_y    <= i_y;
            r_z    <= i_z;
            r_best <= n_best;
        end
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_best  = r_best;

endmodule

`default_nettype wire

[rtl/ncc_count.sv]
// Confusion-matrix counter stage: counter memory read, saturating update with
// write forwarding, and the result register. Uses ncc_pkg.
`default_nettype none

module ncc_count #(
    parameter int NUM_CLASSES = 6,
    parameter int COUNT_BITS  = 16,
    parameter int DIST_BITS   = 26
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire ncc_pkg::t_tag                      i_tag,
    input  wire logic [DIST_BITS-1:0]               i_best,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic [ncc_pkg::FIELD_BITS-1:0]          o_winner,
    output logic [ncc_pkg::DIST_OUT_BITS-1:0]       o_min_squared_distance,
    output logic [COUNT_BITS-1:0]                   o_count_value
);
    import ncc_pkg::*;

    localparam int RB    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int AW    = 2 * RB;
    localparam int DEPTH = 1 << AW;
    localparam int XW    = (DIST_BITS > DIST_OUT_BITS) ? DIST_BITS : DIST_OUT_BITS;

    logic [COUNT_BITS-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]      r_vld;

    logic                  r_b_valid;
    t_tag                  r_b_tag;
    logic [DIST_BITS-1:0]  r_b_best;
    logic [AW-1:0]         r_b_addr;
    logic [COUNT_BITS-1:0] r_b_rd;
    logic                  r_fw_en;
    logic [AW-1:0]         r_fw_addr;
    logic [COUNT_BITS-1:0] r_fw_data;

    logic                     r_o_valid;
    logic [FIELD_BITS-1:0]    r_o_win;
    logic [DIST_OUT_BITS-1:0] r_o_dist;
    logic [COUNT_BITS-1:0]    r_o_cnt;

    logic                     out_load, b_move, b_load, b_wr, b_clr, row_ok, col_ok;
    logic [AW-1:0]            rd_addr;
    logic [COUNT_BITS-1:0]    old, incr;
    logic [XW-1:0]            best_x;
    logic [DIST_OUT_BITS-1:0] dist_sat;
    logic [FIELD_BITS-1:0]    n_win;
    logic [DIST_OUT_BITS-1:0] n_dist;
    logic [COUNT_BITS-1:0]    n_cnt;

    assign out_load = !r_o_valid || i_ready;
    assign b_move   = r_b_valid && out_load;
    assign b_load   = !r_b_valid || out_load;
    assign o_ready  = b_load;

    assign rd_addr = (i_tag.mode == MODE_READ) ? {i_tag.row[RB-1:0], i_tag.col[RB-1:0]}
                                               : {i_tag.row[RB-1:0], i_tag.win[RB-1:0]};

    always_comb begin
        row_ok = {1'b0, r_b_tag.row} < (FIELD_BITS+1)'(NUM_CLASSES);
        col_ok = {1'b0, r_b_tag.col} < (FIELD_BITS+1)'(NUM_CLASSES);
        // previous item wrote this address at the edge this item was read
        if (!r_vld[r_b_addr]) begin
            old = '0;
        end else if (r_fw_en && r_fw_addr == r_b_addr) begin
            old = r_fw_data;
        end else begin
            old = r_b_rd;
        end
        incr     = (old == '1) ? old : old + COUNT_BITS'(1);
        best_x   = XW'(r_b_best);
        dist_sat = (best_x > XW'({DIST_OUT_BITS{1'b1}})) ? '1 : best_x[DIST_OUT_BITS-1:0];

        n_win  = '0;
        n_dist = '0;
        n_cnt  = '0;
        b_wr   = 1'b0;
        b_clr  = 1'b0;
        case (r_b_tag.mode)
            MODE_CLASSIFY: begin
                n_win  = r_b_tag.win;
                n_dist = dist_sat;
                if (row_ok) begin
                    b_wr  = 1'b1;
                    n_cnt = incr;
                end
            end
            MODE_READ: begin
                if (row_ok && col_ok) begin
                    n_cnt = old;
                end
            end
            MODE_CLEAR: begin
                b_clr = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (b_move && b_wr) begin
            r_mem[r_b_addr] <= incr;
        end
        if (b_load) begin
            r_b_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_b_valid <= 1'b0;
            r_fw_en   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (b_move && b_clr) begin
                r_vld <= '0;
            end else if (b_move && b_wr) begin
                r_vld[r_b_addr] <= 1'b1;
            end
            if (b_load) begin
                r_b_valid <= i_valid;
                r_fw_en   <= b_move && b_wr;
            end
            if (out_load) begin
                r_o_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_load) begin
            r_fw_addr <= r_b_addr;
            r_fw_data <= incr;
            if (i_valid) begin
                r_b_tag  <= i_tag;
                r_b_best <= i_best;
                r_b_addr <= rd_addr;
            end
        end
        if (b_move) begin
            r_o_win  <= n_win;
            r_o_dist <= n_dist;
            r_o_cnt  <= n_cnt;
        end
    end

    assign o_valid                = r_o_valid;
    assign o_winner               = r_o_win;
    assign o_min_squared_distance = r_o_dist;
    assign o_count_value          = r_o_cnt;

endmodule

`default_nettype wire
